[src/fkr_pkg.sv]
// Shared types and constants for the keyed-removal queue.
`timescale 1ns / 1ps

package fkr_pkg;

	// Operation codes carried on the op port
	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_DROP = 2'd2
	} op_t;

	// Width of the reported fill count; the count is masked to it
	localparam int FILL_W = 5;

	// Per-cell control for one accepted item
	typedef struct packed {
		logic deq;       // shift the whole row towards the head
		logic drop;      // compare keys and close the gap after the first hit
		logic load;      // this cell is the tail slot of an enqueue
		logic occupied;  // this cell holds a live entry
	} cell_ctrl_t;

endpackage

[src/fkr_cell.sv]
// One storage cell of the queue row: key, payload, compare and shift.
`timescale 1ns / 1ps

module fkr_cell #(
	parameter int KEY_W = 48,
	parameter int PAY_W = 64
) (
	input  logic               clk,
	input  fkr_pkg::cell_ctrl_t ctrl,
	input  logic [KEY_W-1:0]   key_in,
	input  logic [PAY_W-1:0]   pay_in,
	input  logic [KEY_W-1:0]   nb_key,
	input  logic [PAY_W-1:0]   nb_pay,
	input  logic               found_in,
	output logic               found_out,
	output logic [KEY_W-1:0]   key_cur,
	output logic [PAY_W-1:0]   pay_cur,
	output logic [KEY_W-1:0]   key_nxt,
	output logic [PAY_W-1:0]   pay_nxt
);
	import fkr_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic             hit;
	logic             shift;

	// Compare the stored key and extend the first-match chain
	assign hit       = ctrl.drop & ctrl.occupied & (key_q == key_in);
	assign found_out = found_in | hit;

	// Take the neighbour's entry when removing here or closer to the head
	assign shift = ctrl.deq | (ctrl.drop & found_out);

	always_comb begin
		if (ctrl.load) begin
			key_nxt = key_in;
			pay_nxt = pay_in;
		end else if (shift) begin
			key_nxt = nb_key;
			pay_nxt = nb_pay;
		end else begin
			key_nxt = key_q;
			pay_nxt = pay_q;
		end
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		key_q <= key_nxt;
		pay_q <= pay_nxt;
	end

	assign key_cur = key_q;
	assign pay_cur = pay_q;

endmodule

[src/fifo_with_keyed_removal.sv]
// Top level of the ordered queue with enqueue, dequeue and drop by key.
`timescale 1ns / 1ps

// Ordered queue of up to QUEUE_DEPTH entries held in a row of cells. Each
// command is taken when it is given: busy stays low, so a new command may be
// given on every clock. Enqueue writes the tail cell, dequeue shifts the whole
// row one place towards the head, and drop compares every cell's key at once
// and shifts every cell from the first match onwards. The result appears on
// the cycle after the command, marked by done for exactly one cycle, and
// must be taken then: there is no way to hold it. The first-match search is
// a ripple through the cells, so its path grows with QUEUE_DEPTH.
module fifo_with_keyed_removal #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int KEY_CHARS    = 6,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              op,
	input  logic [KEY_CHARS*8-1:0]  key_text,
	input  logic [PAYLOAD_BITS-1:0] payload_tag,
	output logic                    done,
	output logic                    ok,
	output logic                    head_valid,
	output logic [KEY_CHARS*8-1:0]  head_key,
	output logic [PAYLOAD_BITS-1:0] head_payload,
	output logic [fkr_pkg::FILL_W-1:0] fill_count
);
	import fkr_pkg::*;

	localparam int KEY_W = KEY_CHARS * 8;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             accept;
	logic             is_enq;
	logic             is_deq;
	logic             is_drop;
	logic             enq_ok;
	logic             deq_ok;
	logic             drop_ok;
	logic             op_ok;

	logic [KEY_W-1:0]        key_cur [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0] pay_cur [QUEUE_DEPTH];
	logic [KEY_W-1:0]        key_nxt [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0] pay_nxt [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0]    found;
	cell_ctrl_t              ctrl    [QUEUE_DEPTH];

	logic                    done_q;
	logic                    ok_q;
	logic                    head_valid_q;
	logic [KEY_W-1:0]        head_key_q;
	logic [PAYLOAD_BITS-1:0] head_payload_q;
	logic [FILL_W-1:0]       fill_count_q;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Decode the command
	always_comb begin
		is_enq  = 1'b0;
		is_deq  = 1'b0;
		is_drop = 1'b0;
		case (op_t'(op))
			OP_ENQ:  is_enq  = accept;
			OP_DEQ:  is_deq  = accept;
			OP_DROP: is_drop = accept;
			default: ;
		endcase
	end

	assign enq_ok  = is_enq & (count_q < CNT_W'(QUEUE_DEPTH));
	assign deq_ok  = is_deq & (count_q != '0);
	assign drop_ok = found[QUEUE_DEPTH];
	assign op_ok   = enq_ok | deq_ok | drop_ok;

	// Row of cells, each fed by its neighbour towards the tail; the last cell feeds itself
	assign found[0] = 1'b0;
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign ctrl[i].deq      = deq_ok;
		assign ctrl[i].drop     = is_drop;
		assign ctrl[i].load     = enq_ok & (count_q == CNT_W'(i));
		assign ctrl[i].occupied = (CNT_W'(i) < count_q);

		if (i == QUEUE_DEPTH - 1) begin : g_last
			fkr_cell #(.KEY_W(KEY_W), .PAY_W(PAYLOAD_BITS)) u_cell (
				.clk      (clk),
				.ctrl     (ctrl[i]),
				.key_in   (key_text),
				.pay_in   (payload_tag),
				.nb_key   (key_cur[i]),
				.nb_pay   (pay_cur[i]),
				.found_in (found[i]),
				.found_out(found[i+1]),
				.key_cur  (key_cur[i]),
				.pay_cur  (pay_cur[i]),
				.key_nxt  (key_nxt[i]),
				.pay_nxt  (pay_nxt[i])
			);
		end else begin : g_mid
			fkr_cell #(.KEY_W(KEY_W), .PAY_W(PAYLOAD_BITS)) u_cell (
				.clk      (clk),
				.ctrl     (ctrl[i]),
				.key_in   (key_text),
				.pay_in   (payload_tag),
				.nb_key   (key_cur[i+1]),
				.nb_pay   (pay_cur[i+1]),
				.found_in (found[i]),
				.found_out(found[i+1]),
				.key_cur  (key_cur[i]),
				.pay_cur  (pay_cur[i]),
				.key_nxt  (key_nxt[i]),
				.pay_nxt  (pay_nxt[i])
			);
		end
	end

	// Advance the entry count
	always_comb begin
		count_d = count_q;
		if (enq_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (deq_ok | drop_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	// Capture the result of the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q           <= op_ok;
			head_valid_q   <= (count_d != '0);
			head_key_q     <= (count_d != '0) ? key_nxt[0] : '0;
			head_payload_q <= (count_d != '0) ? pay_nxt[0] : '0;
			fill_count_q   <= FILL_W'(count_d);
		end
	end

	assign done         = done_q;
	assign ok           = ok_q;
	assign head_valid   = head_valid_q;
	assign head_key     = head_key_q;
	assign head_payload = head_payload_q;
	assign fill_count   = fill_count_q;

	// Checks
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result strobe missing after accepted item");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (head_valid == (count_q != '0)))
		else $error("head valid disagrees with entry count");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !head_valid) |-> (head_key == '0 && head_payload == '0))
		else $error("head fields not cleared on empty queue");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("entry count moved without an item");

endmodule

[verif/tb.sv]
// Self-checking testbench for the keyed-removal queue: directed and random commands.
`timescale 1ns / 1ps

module tb;
	import fkr_pkg::*;

	localparam int KEY_W = 48;
	localparam int PAY_W = 64;
	localparam int DEPTH = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]       cmd;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] pay;
		int               gap;
		bit               drain_first;
	} command_t;

	typedef struct {
		logic             ok;
		logic             head_valid;
		logic [KEY_W-1:0] head_key;
		logic [PAY_W-1:0] head_payload;
		logic [FILL_W-1:0] fill_count;
	} queue_status_t;

	typedef struct {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] pay;
	} held_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] op = OP_ENQ;
	logic [KEY_W-1:0] key_text = '0;
	logic [PAY_W-1:0] payload_tag = '0;
	logic busy;
	logic done;
	logic ok;
	logic head_valid;
	logic [KEY_W-1:0] head_key;
	logic [PAY_W-1:0] head_payload;
	logic [FILL_W-1:0] fill_count;

	command_t pending_commands[$];
	queue_status_t status_expected[$];
	held_entry_t held_entries[$];
	logic [KEY_W-1:0] key_pool[6];
	int faults = 0;
	int gap_left = 0;
	bit gap_loaded = 1'b0;
	bit drained = 1'b1;

	fifo_with_keyed_removal u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.key_text(key_text),
		.payload_tag(payload_tag),
		.done(done),
		.ok(ok),
		.head_valid(head_valid),
		.head_key(head_key),
		.head_payload(head_payload),
		.fill_count(fill_count)
	);

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one command to the queue image and return the status it reports
	function automatic queue_status_t predict_queue_status(input logic [1:0] cmd,
			input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] pay);
		queue_status_t s;
		held_entry_t e;
		int hit;
		s.ok = 1'b0;
		hit = -1;
		case (cmd)
			OP_ENQ: begin
				if (held_entries.size() < DEPTH) begin
					e.key = key;
					e.pay = pay;
					held_entries.push_back(e);
					s.ok = 1'b1;
				end
			end
			OP_DEQ: begin
				if (held_entries.size() > 0) begin
					void'(held_entries.pop_front());
					s.ok = 1'b1;
				end
			end
			OP_DROP: begin
				for (int i = 0; i < held_entries.size(); i++)
					if (hit < 0 && held_entries[i].key == key)
						hit = i;
				if (hit >= 0) begin
					held_entries.delete(hit);
					s.ok = 1'b1;
				end
			end
			default: ;
		endcase
		s.head_valid = held_entries.size() > 0;
		s.head_key = s.head_valid ? held_entries[0].key : '0;
		s.head_payload = s.head_valid ? held_entries[0].pay : '0;
		s.fill_count = FILL_W'(held_entries.size());
		return s;
	endfunction

	function automatic logic [KEY_W-1:0] random_key();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[KEY_W-1:0];
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(99, 0) < 80)
			return key_pool[$urandom_range(5, 0)];
		return random_key();
	endfunction

	// Mostly no gap, some short ones, a few long ones
	function automatic int pick_gap(input bit gappy);
		int r;
		if (!gappy)
			return 0;
		r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic add_command(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] pay, input int gap, input bit drain_first);
		command_t c;
		c.cmd = cmd;
		c.key = key;
		c.pay = pay;
		c.gap = gap;
		c.drain_first = drain_first;
		pending_commands.push_back(c);
	endtask

	// Note when nothing is outstanding; read by the driver at the next edge
	always @(negedge clk)
		drained <= (status_expected.size() == 0);

	// Driver: predict on acceptance, then present the next item after its gap
	always @(posedge clk or negedge arst_n) begin
		command_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
			gap_loaded = 1'b0;
		end else begin
			if (start && !busy)
				status_expected.push_back(predict_queue_status(op, key_text, payload_tag));
			if (start && busy) begin
				// hold the item until it is taken
			end else if (pending_commands.size() == 0) begin
				start <= 1'b0;
			end else begin
				if (!gap_loaded) begin
					gap_left = pending_commands[0].gap;
					gap_loaded = 1'b1;
				end
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_commands[0].drain_first && !(drained && !start)) begin
					start <= 1'b0;
				end else begin
					nxt = pending_commands.pop_front();
					gap_loaded = 1'b0;
					op <= nxt.cmd;
					key_text <= nxt.key;
					payload_tag <= nxt.pay;
					start <= 1'b1;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			faults++;
		end
	endtask

	// Monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		queue_status_t want;
		if (arst_n && done) begin
			if (status_expected.size() == 0) begin
				$display("%0t: result with nothing expected, actual ok %b fill %0d",
					$time, ok, fill_count);
				faults++;
			end else begin
				want = status_expected.pop_front();
				check_field("ok", 64'(want.ok), 64'(ok));
				check_field("head_valid", 64'(want.head_valid), 64'(head_valid));
				check_field("head_key", 64'(want.head_key), 64'(head_key));
				check_field("head_payload", want.head_payload, head_payload);
				check_field("fill_count", 64'(want.fill_count), 64'(fill_count));
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int mode;
		bit gappy;
		for (int i = 0; i < 6; i++)
			key_pool[i] = random_key();
		key_pool[5] = '1;

		// Empty queue: every removal fails, unused code reports empty
		add_command(OP_DEQ, random_key(), {$urandom, $urandom}, 0, 1'b0);
		add_command(OP_DROP, '0, {$urandom, $urandom}, 1, 1'b0);
		add_command(OP_UNUSED, random_key(), {$urandom, $urandom}, 0, 1'b0);
		// Drop the sole entry
		add_command(OP_ENQ, '0, '0, 0, 1'b0);
		add_command(OP_DROP, '0, '1, 2, 1'b0);
		// Fill to the brim with extreme and repeated keys
		add_command(OP_ENQ, '1, '1, 0, 1'b0);
		for (int i = 1; i < DEPTH; i++)
			add_command(OP_ENQ, key_pool[i % 5], {$urandom, $urandom}, pick_gap(i[0]), 1'b0);
		add_command(OP_ENQ, random_key(), {$urandom, $urandom}, 0, 1'b0);
		add_command(OP_UNUSED, key_pool[1], {$urandom, $urandom}, 0, 1'b0);
		// First match of a repeated key, then a key that is not held
		add_command(OP_DROP, key_pool[1], {$urandom, $urandom}, 0, 1'b0);
		add_command(OP_DROP, 48'h0, '0, 1, 1'b0);
		add_command(OP_DEQ, '1, '1, 0, 1'b1);

		// Random blocks, each with its own mix of commands and idling
		for (int b = 0; b < 25; b++) begin
			mode = $urandom_range(2, 0);
			gappy = $urandom_range(2, 0) != 0;
			for (int i = 0; i < 40; i++) begin
				int r;
				logic [1:0] cmd;
				r = $urandom_range(99, 0);
				case (mode)
					0: cmd = r < 70 ? OP_ENQ : r < 80 ? OP_DEQ : r < 96 ? OP_DROP : OP_UNUSED;
					1: cmd = r < 45 ? OP_ENQ : r < 70 ? OP_DEQ : r < 95 ? OP_DROP : OP_UNUSED;
					default: cmd = r < 25 ? OP_ENQ : r < 55 ? OP_DEQ : r < 96 ? OP_DROP
						: OP_UNUSED;
				endcase
				add_command(cmd, pick_key(), {$urandom, $urandom}, pick_gap(gappy),
					i == 0 && b % 5 == 4);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every item is taken and every result has come
		@(posedge clk);
		while (pending_commands.size() != 0 || start || status_expected.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (faults == 0 && status_expected.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Hard limit on run length
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
